/* hdl/dsms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: shared package
// Constants, reduction factors and state types used across the block.
// ----------------------------------------------------------------------------
package dsms_pkg;

  localparam int NUM_BITS_DEF = 63;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int RES_W = 30;

  localparam logic [RES_W-1:0] MOD_P = 30'd1000000007;
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CHECK,
    B_WAIT,
    B_SUM
  } back_state_t;

endpackage

/* hdl/dsms_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: front end
// Converts each item to decimal bit by bit, then scans its digits to form the
// reduced base and the exponent, and pushes them into the queue.
// ----------------------------------------------------------------------------
module dsms_front #(
  parameter int NUM_BITS = dsms_pkg::NUM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [NUM_BITS-1:0]        in_encoded,
  input  logic                       in_last,
  output logic                       q_wr_valid,
  input  logic                       q_full,
  output logic [dsms_pkg::RES_W-1:0] q_wr_xr,
  output logic [NUM_BITS-1:0]        q_wr_y,
  output logic                       q_wr_last
);
  import dsms_pkg::*;

  localparam int NUM_DIGITS = ((NUM_BITS * 1233) >> 12) + 1;
  localparam int BCD_W = NUM_DIGITS * 4;
  localparam int CNT_W = $clog2(NUM_BITS + 1);
  localparam int IDX_W = $clog2(NUM_DIGITS);
  localparam int I_W = ((IDX_W > 4) ? IDX_W : 4) + 1;
  localparam logic [33:0] MOD_P34 = 34'(MOD_P);

  front_state_t state_r, state_nxt;
  logic [NUM_BITS-1:0] val_r, val_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [3:0]          w_r, w_nxt;
  logic [I_W-1:0]      i_r, i_nxt;
  logic [I_W-1:0]      step_r, step_nxt;
  logic                started_r, started_nxt;
  logic [RES_W-1:0]    x_r, x_nxt;
  logic [NUM_BITS-1:0] y_r, y_nxt;
  logic                last_r, last_nxt;

  logic [BCD_W-1:0]    bcd_adj;
  logic [BCD_W-1:0]    bcd_shift;
  logic [3:0]          dig;
  logic [33:0]         x_ext;
  logic [33:0]         x_red;
  logic [NUM_BITS-1:0] y_new;

  always_comb begin
    for (int k = 0; k < NUM_DIGITS; k++) begin
      if (bcd_r[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd_r[4*k +: 4];
      end
    end
    bcd_shift = {bcd_adj[BCD_W-2:0], val_r[NUM_BITS-1]};
  end

  assign dig = bcd_r[BCD_W-1 -: 4];
  assign x_ext = ({4'b0, x_r} << 3) + ({4'b0, x_r} << 1) + {30'b0, dig};
  assign y_new = (y_r << 3) + (y_r << 1) + NUM_BITS'(dig);

  always_comb begin
    x_red = x_ext;
    for (int k = 1; k < 10; k++) begin
      if (x_ext >= 34'(k) * MOD_P34) begin
        x_red = x_ext - 34'(k) * MOD_P34;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    val_r     <= val_nxt;
    bcd_r     <= bcd_nxt;
    cnt_r     <= cnt_nxt;
    w_r       <= w_nxt;
    i_r       <= i_nxt;
    step_r    <= step_nxt;
    started_r <= started_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    last_r    <= last_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    bcd_nxt     = bcd_r;
    cnt_nxt     = cnt_r;
    w_nxt       = w_r;
    i_nxt       = i_r;
    step_nxt    = step_r;
    started_nxt = started_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    last_nxt    = last_r;
    in_stall    = 1'b1;
    q_wr_valid  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          val_nxt   = in_encoded;
          bcd_nxt   = '0;
          cnt_nxt   = '0;
          last_nxt  = in_last;
          state_nxt = F_CONV;
        end
      end
      F_CONV: begin
        bcd_nxt = bcd_shift;
        val_nxt = val_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_BITS - 1)) begin
          w_nxt       = bcd_shift[3:0];
          i_nxt       = '0;
          step_nxt    = '0;
          started_nxt = 1'b0;
          x_nxt       = '0;
          y_nxt       = '0;
          state_nxt   = F_SCAN;
        end
      end
      F_SCAN: begin
        bcd_nxt  = bcd_r << 4;
        step_nxt = step_r + 1'b1;
        if (started_r || (dig != 4'd0)) begin
          started_nxt = 1'b1;
          i_nxt = i_r + 1'b1;
          if (i_r < {{(I_W-4){1'b0}}, w_r}) begin
            x_nxt = x_red[RES_W-1:0];
          end else begin
            y_nxt = y_new;
          end
        end
        if (step_r == I_W'(NUM_DIGITS - 2)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        q_wr_valid = 1'b1;
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign q_wr_xr   = x_r;
  assign q_wr_y    = y_r;
  assign q_wr_last = last_r;

endmodule

/* hdl/dsms_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: work queue
// A short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module dsms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dsms_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             full,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_pop,
  output logic [WIDTH-1:0] rd_data
);
  import dsms_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && !full;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/dsms_modmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: modular multiplier
// Five-stage pipelined product modulo the prime, with Barrett reduction.
// ----------------------------------------------------------------------------
module dsms_modmul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dsms_pkg::RES_W-1:0] a,
  input  logic [dsms_pkg::RES_W-1:0] b,
  output logic                       done,
  output logic [dsms_pkg::RES_W-1:0] result
);
  import dsms_pkg::*;

  logic [4:0]       vld_r;
  logic [59:0]      p1_r;
  logic [59:0]      p2_r;
  logic [61:0]      q2_r;
  logic [31:0]      p3_r;
  logic [31:0]      qp_r;
  logic [31:0]      r4_r;
  logic [RES_W-1:0] res_r;
  logic [60:0]      qp_full;
  logic [31:0]      r_fix;

  assign qp_full = q2_r[61:31] * MOD_P;

  always_comb begin
    if (r4_r >= {1'b0, MOD_P, 1'b0}) begin
      r_fix = r4_r - {1'b0, MOD_P, 1'b0};
    end else if (r4_r >= {2'b0, MOD_P}) begin
      r_fix = r4_r - {2'b0, MOD_P};
    end else begin
      r_fix = r4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
    p1_r  <= a * b;
    p2_r  <= p1_r;
    q2_r  <= p1_r[59:29] * BARRETT_MU;
    p3_r  <= p2_r[31:0];
    qp_r  <= qp_full[31:0];
    r4_r  <= p3_r - qp_r;
    res_r <= r_fix[RES_W-1:0];
  end

  assign done   = vld_r[4];
  assign result = res_r;

endmodule

/* hdl/dsms_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: back end
// Runs square-and-multiply on each queued item, keeps the running sum and
// holds the result register towards the output channel.
// ----------------------------------------------------------------------------
module dsms_back #(
  parameter int NUM_BITS = dsms_pkg::NUM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       q_pop,
  input  logic [dsms_pkg::RES_W-1:0] q_xr,
  input  logic [NUM_BITS-1:0]        q_y,
  input  logic                       q_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dsms_pkg::RES_W-1:0] out_total
);
  import dsms_pkg::*;

  back_state_t state_r, state_nxt;
  logic [RES_W-1:0]    acc_r, acc_nxt;
  logic [RES_W-1:0]    base_r, base_nxt;
  logic [NUM_BITS-1:0] exp_r, exp_nxt;
  logic                last_r, last_nxt;
  logic [RES_W-1:0]    sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RES_W-1:0]    out_total_r, out_total_nxt;

  logic             mul_start;
  logic             done_acc;
  logic             done_sq;
  logic [RES_W-1:0] prod_acc;
  logic [RES_W-1:0] prod_sq;
  logic [RES_W:0]   sum_wide;
  logic [RES_W-1:0] sum_mod;

  dsms_modmul u_mul_acc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (acc_r),
    .b      (base_r),
    .done   (done_acc),
    .result (prod_acc)
  );

  dsms_modmul u_mul_sq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .a      (base_r),
    .b      (base_r),
    .done   (done_sq),
    .result (prod_sq)
  );

  assign sum_wide = {1'b0, sum_r} + {1'b0, acc_r};
  assign sum_mod  = (sum_wide >= {1'b0, MOD_P}) ?
                    RES_W'(sum_wide - {1'b0, MOD_P}) : sum_wide[RES_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    acc_r       <= acc_nxt;
    base_r      <= base_nxt;
    exp_r       <= exp_nxt;
    last_r      <= last_nxt;
    out_total_r <= out_total_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    base_nxt      = base_r;
    exp_nxt       = exp_r;
    last_nxt      = last_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_total_nxt = out_total_r;
    q_pop         = 1'b0;
    mul_start     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          acc_nxt   = RES_W'(1);
          base_nxt  = q_xr;
          exp_nxt   = q_y;
          last_nxt  = q_last;
          state_nxt = B_CHECK;
        end
      end
      B_CHECK: begin
        if (exp_r == '0) begin
          state_nxt = B_SUM;
        end else begin
          mul_start = 1'b1;
          state_nxt = B_WAIT;
        end
      end
      B_WAIT: begin
        if (done_acc && done_sq) begin
          if (exp_r[0]) begin
            acc_nxt = prod_acc;
          end
          base_nxt  = prod_sq;
          exp_nxt   = exp_r >> 1;
          state_nxt = B_CHECK;
        end
      end
      B_SUM: begin
        if (!last_r) begin
          sum_nxt   = sum_mod;
          state_nxt = B_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = sum_mod;
          sum_nxt       = '0;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_total = out_total_r;

endmodule

/* hdl/decimal_split_modexp_sum_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: top level
// The front end takes a new item only after it has pushed the last one into the
// queue; the back end runs each item through the five-stage modular multipliers
// once per exponent bit, and the two overlap through the queue.
// Reset is synchronous, active low, and clears the running sum and the queue.
// ----------------------------------------------------------------------------
module decimal_split_modexp_sum_unit #(
  parameter int NUM_BITS = dsms_pkg::NUM_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [NUM_BITS-1:0]        in_encoded,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [dsms_pkg::RES_W-1:0] out_total
);
  import dsms_pkg::*;

  localparam int Q_W = RES_W + NUM_BITS + 1;

  logic             wr_valid;
  logic             q_full;
  logic [RES_W-1:0] wr_xr;
  logic [NUM_BITS-1:0] wr_y;
  logic             wr_last;
  logic             rd_valid;
  logic             rd_pop;
  logic [Q_W-1:0]   rd_data;

  dsms_front #(.NUM_BITS(NUM_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_encoded (in_encoded),
    .in_last    (in_last),
    .q_wr_valid (wr_valid),
    .q_full     (q_full),
    .q_wr_xr    (wr_xr),
    .q_wr_y     (wr_y),
    .q_wr_last  (wr_last)
  );

  dsms_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH_DEF)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .full     (q_full),
    .wr_data  ({wr_last, wr_xr, wr_y}),
    .rd_valid (rd_valid),
    .rd_pop   (rd_pop),
    .rd_data  (rd_data)
  );

  dsms_back #(.NUM_BITS(NUM_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (rd_valid),
    .q_pop     (rd_pop),
    .q_xr      (rd_data[NUM_BITS +: RES_W]),
    .q_y       (rd_data[NUM_BITS-1:0]),
    .q_last    (rd_data[Q_W-1]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_total (out_total)
  );

endmodule

/* hdl/dsms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Decimal split modular power sum: port checker
// Watches the top-level ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dsms_checker #(
  parameter int NUM_BITS = dsms_pkg::NUM_BITS_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [NUM_BITS-1:0]        in_encoded,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [dsms_pkg::RES_W-1:0] out_total
);
  import dsms_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total))
    else $error("result changed while the transfer was stalled");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_total < MOD_P))
    else $error("result total is not reduced below the modulus");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_encoded == in_encoded) && (in_last == in_last)
    |=> in_stall)
    else $error("input taken again right after a transfer");

endmodule

bind decimal_split_modexp_sum_unit dsms_checker #(.NUM_BITS(NUM_BITS)) u_dsms_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_encoded (in_encoded),
  .in_last    (in_last),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_total  (out_total)
);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the decimal split modular power sum unit
// Directed and random lists of encoded numbers are sent under varying idle and
// stall patterns; each total is checked against a listed or predicted total.
// ----------------------------------------------------------------------------
module tb;

  localparam int NB = dsms_pkg::NUM_BITS_DEF;
  localparam longint unsigned PRIME = 64'd1000000007;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 500;
  localparam int N_RANDOM = 1680;

  typedef struct {
    logic [NB-1:0]           enc;
    logic                    last;
    bit                      typed;
    logic [dsms_pkg::RES_W-1:0] total;
  } row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [NB-1:0]              in_encoded;
  logic                       in_last;
  logic                       out_valid;
  logic                       out_stall;
  logic [dsms_pkg::RES_W-1:0] out_total;

  longint unsigned            list_sum;
  logic [dsms_pkg::RES_W-1:0] expected_totals[$];
  int                         mismatches;
  int                         items_sent;
  int                         totals_seen;
  int                         mode;
  int                         hold_count = 0;
  bit                         hold_req;
  bit                         accepted_now;
  row_t                       rows[$];

  decimal_split_modexp_sum_unit #(.NUM_BITS(NB)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_encoded(in_encoded),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_total (out_total)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned split_power(logic [NB-1:0] enc);
    longint unsigned v;
    longint unsigned w;
    longint unsigned r;
    longint unsigned x;
    longint unsigned y;
    longint unsigned acc;
    longint unsigned b;
    int unsigned     dig[20];
    int              n;
    v = 64'(enc);
    w = v % 10;
    r = v / 10;
    n = 0;
    do begin
      dig[n] = 32'(r % 10);
      r = r / 10;
      n++;
    end while (r != 0);
    x = 0;
    y = 0;
    for (int i = 0; i < n; i++) begin
      if (i < w) x = x * 10 + dig[n-1-i];
      else y = y * 10 + dig[n-1-i];
    end
    acc = 1;
    b = x % PRIME;
    while (y != 0) begin
      if (y[0]) acc = (acc * b) % PRIME;
      b = (b * b) % PRIME;
      y = y >> 1;
    end
    return acc;
  endfunction

  task automatic report(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_item(logic [NB-1:0] enc, logic last, bit typed,
                           logic [dsms_pkg::RES_W-1:0] total);
    int pct;
    in_valid   <= 1'b1;
    in_encoded <= enc;
    in_last    <= last;
    do @(posedge clk); while (in_stall);
    list_sum = (list_sum + split_power(enc)) % PRIME;
    if (last) begin
      expected_totals.insert(expected_totals.size(),
                             typed ? total : list_sum[dsms_pkg::RES_W-1:0]);
      list_sum = 0;
    end
    items_sent++;
    pct = (mode == 1) ? 67 : (mode == 3) ? 13 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic row_t mk(logic [NB-1:0] enc, logic last, bit typed,
                              logic [dsms_pkg::RES_W-1:0] total);
    row_t r;
    r.enc = enc;
    r.last = last;
    r.typed = typed;
    r.total = total;
    return r;
  endfunction

  function automatic logic [NB-1:0] random_encoded();
    logic [NB-1:0] e;
    case ($urandom_range(0, 3))
      0: e = NB'({$urandom, $urandom});
      1: e = NB'($urandom_range(0, 999999) * 10 + $urandom_range(0, 9));
      default: e = NB'({$urandom_range(0, 15), $urandom} * 10 + $urandom_range(0, 9));
    endcase
    return e;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else begin
      out_stall <= ((mode == 2 && $urandom_range(0, 99) < 67) ||
                    (mode == 3 && $urandom_range(0, 99) < 13));
    end
  end

  always @(posedge clk) begin
    accepted_now = (in_valid && !in_stall) || (out_valid && !out_stall);
    if (rst_n && out_valid && !out_stall) begin
      totals_seen++;
      if (expected_totals.size() == 0) begin
        report("unexpected total", 64'(out_total), 64'd0);
      end else begin
        if (out_total !== expected_totals[0])
          report("total", 64'(out_total), 64'(expected_totals[0]));
        void'(expected_totals.pop_front());
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if (accepted_now || !rst_n) idle = 0;
      else idle++;
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d totals outstanding", expected_totals.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_encoded = '0;
    in_last = 1'b0;
    list_sum = 0;
    mismatches = 0;
    items_sent = 0;
    totals_seen = 0;
    mode = 0;
    hold_req = 1'b0;
    rows.insert(rows.size(), mk(63'd0, 1'b1, 1'b1, 30'd1));
    rows.insert(rows.size(), mk(63'd5, 1'b1, 1'b1, 30'd1));
    rows.insert(rows.size(), mk(63'd230, 1'b1, 1'b1, 30'd0));
    rows.insert(rows.size(), mk(63'd2101, 1'b1, 1'b1, 30'd1024));
    rows.insert(rows.size(), mk(63'd1239, 1'b1, 1'b1, 30'd1));
    rows.insert(rows.size(), mk(63'd19, 1'b1, 1'b1, 30'd1));
    rows.insert(rows.size(), mk(63'd10, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd31, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd21, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd2101, 1'b1, 1'b1, 30'd1026));
    rows.insert(rows.size(), mk({NB{1'b1}}, 1'b1, 1'b0, '0));
    rows.insert(rows.size(), mk(63'h4000_0000_0000_0000, 1'b1, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd999999999999999990, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd999999999999999991, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd999999999999999999, 1'b1, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd10000000070, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd10000000079, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'd2999999999999999993, 1'b1, 1'b0, '0));
    rows.insert(rows.size(), mk(63'h2AAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0));
    rows.insert(rows.size(), mk(63'h5555_5555_5555_5555, 1'b1, 1'b0, '0));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].enc, rows[i].last, rows[i].typed, rows[i].total);
    drain();
    hold_req = 1'b1;
    for (int m = 0; m < 4; m++) begin
      mode = m;
      for (int k = 0; k < N_RANDOM / 4; k++)
        send_item(random_encoded(), ($urandom_range(0, 7) == 0), 1'b0, '0);
      send_item(random_encoded(), 1'b1, 1'b0, '0);
      drain();
    end
    mode = 0;
    $display("sent %0d items and checked %0d list totals", items_sent, totals_seen);
    $display("phases: no idling, sender idle, receiver stall, both, plus a long hold-off");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
